FILE: sv/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Entry layout, per-request control group and op codes used by the
// cell chain and the top level.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int ENTRIES = 8;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 4;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic [KEY_W-1:0]         key;
        logic signed [VAL_W-1:0]  value;
    } entry_t;

    // Per-request command shared by every cell in the chain.
    typedef struct packed {
        logic hit;    // accepted request found its key
        logic evict;  // accepted put of a new key with the table full
        logic fill;   // accepted put of a new key with room left
    } ctrl_t;

endpackage

FILE: sv/lru_key_value_cache.sv
// A request accepted at a clock edge has its result registered at that
// same edge and offered on m_* in the next cycle; one request per cycle while m_ready does not stall the output.
// The lookup compares all cells in parallel; the table updates by one shift
// of the recency chain per accepted request other than a get that misses.
// Reset (aresetn low, synchronous) empties the table and sets capacity to 8.
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Entries sit in a chain ordered by recency, most recent at cell 0.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [lkvc_pkg::KEY_W-1:0]        s_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] m_read_value,
    output logic                              m_evicted,
    output logic [lkvc_pkg::KEY_W-1:0]        m_evicted_key
);

    localparam int N = lkvc_pkg::ENTRIES;

    logic [lkvc_pkg::CAP_W-1:0]        capacity_reg;
    logic [lkvc_pkg::CNT_W-1:0]        cap_lim;
    logic                              accept;
    logic                              full;
    logic                              hit;
    logic signed [lkvc_pkg::VAL_W-1:0] hit_value;
    logic [lkvc_pkg::KEY_W-1:0]        last_key;
    lkvc_pkg::ctrl_t                   ctrl;
    lkvc_pkg::entry_t                  head;
    lkvc_pkg::entry_t                  cell_entry [N];
    lkvc_pkg::entry_t                  cell_load  [N];
    logic [N-1:0]                      cell_match;
    logic [N-1:0]                      cell_stop_in;
    logic [N-1:0]                      cell_stop_out;
    logic [N-1:0]                      cell_next_valid;

    logic                              m_valid_reg;
    logic                              hit_reg;
    logic signed [lkvc_pkg::VAL_W-1:0] read_value_reg;
    logic                              evicted_reg;
    logic [lkvc_pkg::KEY_W-1:0]        evicted_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= lkvc_pkg::CAP_W'(8);
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Clamp capacity to 1..ENTRIES.
    always_comb begin
        if (capacity_reg == '0) begin
            cap_lim = lkvc_pkg::CNT_W'(1);
        end else if (int'(capacity_reg) > N) begin
            cap_lim = lkvc_pkg::CNT_W'(N);
        end else begin
            cap_lim = lkvc_pkg::CNT_W'(capacity_reg);
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Valid entries are contiguous from cell 0, so the table is full when
    // the cell at capacity-1 holds an entry; the last valid cell is the LRU.
    always_comb begin
        full      = 1'b0;
        hit_value = '0;
        last_key  = '0;
        for (int i = 0; i < N; i++) begin
            if (cell_entry[i].valid && (i + 1 == int'(cap_lim))) begin
                full = 1'b1;
            end
            if (cell_match[i]) begin
                hit_value = hit_value | cell_entry[i].value;
            end
            if (cell_entry[i].valid && !cell_next_valid[i]) begin
                last_key = last_key | cell_entry[i].key;
            end
        end
    end

    assign hit        = |cell_match;
    assign ctrl.hit   = accept && hit;
    assign ctrl.evict = accept && (s_op == lkvc_pkg::OP_PUT) && !hit && full;
    assign ctrl.fill  = accept && (s_op == lkvc_pkg::OP_PUT) && !hit && !full;

    assign head.valid = 1'b1;
    assign head.key   = s_key;
    assign head.value = (s_op == lkvc_pkg::OP_PUT) ? s_value : hit_value;

    for (genvar g = 0; g < N; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_load[g] = head;
        end else begin : g_body
            assign cell_load[g] = cell_entry[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign cell_stop_in[g]    = 1'b0;
            assign cell_next_valid[g] = 1'b0;
        end else begin : g_mid
            assign cell_stop_in[g]    = cell_stop_out[g+1];
            assign cell_next_valid[g] = cell_entry[g+1].valid;
        end

        lkvc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .lookup_key (s_key),
            .ctrl       (ctrl),
            .load_data  (cell_load[g]),
            .next_valid (cell_next_valid[g]),
            .stop_in    (cell_stop_in[g]),
            .stop_out   (cell_stop_out[g]),
            .match      (cell_match[g]),
            .entry      (cell_entry[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the result until its transfer.
    always_ff @(posedge aclk) begin
        if (accept) begin
            hit_reg         <= hit;
            read_value_reg  <= (hit && (s_op == lkvc_pkg::OP_GET)) ? hit_value : '0;
            evicted_reg     <= ctrl.evict;
            evicted_key_reg <= ctrl.evict ? last_key : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = hit_reg;
    assign m_read_value  = read_value_reg;
    assign m_evicted     = evicted_reg;
    assign m_evicted_key = evicted_key_reg;

endmodule

FILE: sv/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell: one slot of the recency-ordered entry chain
// Position in the chain is the recency rank. On an update the cell takes
// its left neighbor's entry when the replaced slot lies at or beyond it.
// ----------------------------------------------------------------------------
module lkvc_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  lkvc_pkg::ctrl_t   ctrl,
    input  lkvc_pkg::entry_t  load_data,
    input  logic              next_valid,
    input  logic              stop_in,
    output logic              stop_out,
    output logic              match,
    output lkvc_pkg::entry_t  entry
);

    logic                              valid_reg;
    logic [lkvc_pkg::KEY_W-1:0]        key_reg;
    logic signed [lkvc_pkg::VAL_W-1:0] value_reg;
    logic                              stop_here;

    assign match = valid_reg && (key_reg == lookup_key);

    // This slot is the one being replaced: the hit entry, the last valid
    // entry on eviction, or the first free slot on a fill.
    assign stop_here = (ctrl.hit && match)
                     || (ctrl.evict && valid_reg && !next_valid)
                     || (ctrl.fill && !valid_reg && load_data.valid);

    assign stop_out = stop_in || stop_here;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stop_out) begin
            valid_reg <= load_data.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stop_out) begin
            key_reg   <= load_data.key;
            value_reg <= load_data.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;

endmodule
